/* design/strict_utf8_stream_decoder_top_macros.svh */
// Assertion macros for the strict UTF-8 stream decoder.
`ifndef STRICT_UTF8_STREAM_DECODER_TOP_MACROS_SVH
`define STRICT_UTF8_STREAM_DECODER_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during rst
`define SUD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sud assertion failed");
// next-cycle implication
`define SUD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sud assertion failed");
`else
`define SUD_ASSERT_NOW(lbl, ante, cons)
`define SUD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* design/sud_pkg.sv */
// Shared types and constants for the strict UTF-8 stream decoder.
package sud_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] CpMax      = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLo     = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi     = 21'h00DFFF;
  localparam logic [CpW-1:0] Min2       = 21'h000080;
  localparam logic [CpW-1:0] Min3       = 21'h000800;
  localparam logic [CpW-1:0] Min4       = 21'h010000;

  localparam logic [2:0] Len1 = 3'd1;
  localparam logic [2:0] Len2 = 3'd2;
  localparam logic [2:0] Len3 = 3'd3;
  localparam logic [2:0] Len4 = 3'd4;

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusBad = 1'b1;

  typedef struct packed {
    logic [1:0]     bytes_pending;
    logic [2:0]     seq_length;
    logic [CpW-1:0] partial_value;
    logic           skip_to_end;
  } state_t;

  typedef struct packed {
    logic           emit;
    logic [CpW-1:0] code_point;
    logic [2:0]     seq_bytes;
    logic           status;
    logic           text_done;
  } result_t;

endpackage

/* design/sud_in_if.sv */
// Byte channel into the decoder.
interface sud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, text_byte, final_byte, input ready);
  modport sink (input valid, text_byte, final_byte, output ready);
endinterface

/* design/sud_out_if.sv */
// Code point channel out of the decoder.
interface sud_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  seq_bytes;
  logic        status;
  logic        text_done;

  modport source (output valid, code_point, seq_bytes, status, text_done, input ready);
  modport sink (input valid, code_point, seq_bytes, status, text_done, output ready);
endinterface

/* design/strict_utf8_stream_decoder_top.sv */
// Top level of the strict UTF-8 stream decoder.
//
// Usage: bytes of a text arrive on the text channel, one item per
// handshake, final_byte high on the last byte of each text. Each complete
// well-formed sequence gives one item on the result channel with the
// code point and its byte length; the first encoding error of a text
// gives one item with status set and text_done high, and the rest of that
// text is dropped without results.
// Latency: a result appears on the cycle after the byte that completes it.
// Throughput: one byte per cycle while no held result blocks the input; the
// decode step is a single pass of logic between the sequence state and the result register.
// Stall: the result register holds while result.ready is low; a new byte
// is taken when that register is empty or is being emptied in the same
// cycle.
// Reset: rst (synchronous) clears the sequence state, the swallow flag
// and the result valid; the block is ready as soon as rst is low.
`include "strict_utf8_stream_decoder_top_macros.svh"

module strict_utf8_stream_decoder_top (
  input  logic       clk,
  input  logic       rst,
  sud_in_if.sink     text,
  sud_out_if.source  result
);

  sud_pkg::state_t  st;
  sud_pkg::state_t  st_next;
  sud_pkg::result_t res;

  logic                    out_valid;
  logic [sud_pkg::CpW-1:0] code_point;
  logic [2:0]              seq_bytes;
  logic                    status;
  logic                    text_done;
  logic                    accept;

  assign text.ready = !rst && (!out_valid || result.ready);
  assign accept     = text.valid && text.ready;

  sud_step u_step (
    .st         (st),
    .text_byte  (text.text_byte),
    .final_byte (text.final_byte),
    .st_next    (st_next),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        st        <= st_next;
        out_valid <= res.emit;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.emit) begin
      code_point <= res.code_point;
      seq_bytes  <= res.seq_bytes;
      status     <= res.status;
      text_done  <= res.text_done;
    end
  end

  assign result.valid      = out_valid;
  assign result.code_point = code_point;
  assign result.seq_bytes  = seq_bytes;
  assign result.status     = status;
  assign result.text_done  = text_done;

  `SUD_ASSERT_NOW(a_err_fields, out_valid && status, (code_point == '0) && (seq_bytes == 3'd0) && text_done)
  `SUD_ASSERT_NOW(a_ok_len, out_valid && !status, (seq_bytes != 3'd0) && (seq_bytes <= sud_pkg::Len4))
  `SUD_ASSERT_NOW(a_skip_clear, st.skip_to_end, (st.bytes_pending == 2'd0) && (st.partial_value == '0))
  `SUD_ASSERT_NOW(a_pend_len, st.bytes_pending != 2'd0, st.seq_length > {1'b0, st.bytes_pending})
  `SUD_ASSERT_NEXT(a_skip_end, accept && st.skip_to_end && text.final_byte, !st.skip_to_end && !out_valid)

endmodule

/* design/sud_step.sv */
// One decode step: next sequence state and optional result for one byte.
module sud_step (
  input  sud_pkg::state_t  st,
  input  logic [7:0]       text_byte,
  input  logic             final_byte,
  output sud_pkg::state_t  st_next,
  output sud_pkg::result_t res
);

  logic [sud_pkg::CpW-1:0] shifted;
  logic [sud_pkg::CpW-1:0] minimum;
  logic [1:0]              pend_dec;
  logic                    bad_value;

  assign shifted  = {st.partial_value[sud_pkg::CpW-7:0], text_byte[5:0]};
  assign pend_dec = st.bytes_pending - 2'd1;

  always_comb begin
    case (st.seq_length)
      sud_pkg::Len2: minimum = sud_pkg::Min2;
      sud_pkg::Len3: minimum = sud_pkg::Min3;
      default:       minimum = sud_pkg::Min4;
    endcase
  end

  assign bad_value = (shifted < minimum) || (shifted > sud_pkg::CpMax) ||
                     ((shifted >= sud_pkg::SurrLo) && (shifted <= sud_pkg::SurrHi));

  always_comb begin
    logic err;
    logic ok;
    err     = 1'b0;
    ok      = 1'b0;
    st_next = st;
    res     = '0;

    if (st.skip_to_end) begin
      if (final_byte) st_next.skip_to_end = 1'b0;
    end else if (st.bytes_pending == 2'd0) begin
      if (text_byte == 8'h00) begin
        err = 1'b1;
      end else if (text_byte < 8'h80) begin
        ok             = 1'b1;
        res.code_point = sud_pkg::CpW'(text_byte);
        res.seq_bytes  = sud_pkg::Len1;
      end else if (text_byte inside {[8'hC2:8'hDF]}) begin
        st_next.bytes_pending = 2'd1;
        st_next.seq_length    = sud_pkg::Len2;
        st_next.partial_value = sud_pkg::CpW'(text_byte[4:0]);
        err                   = final_byte;
      end else if (text_byte inside {[8'hE0:8'hEF]}) begin
        st_next.bytes_pending = 2'd2;
        st_next.seq_length    = sud_pkg::Len3;
        st_next.partial_value = sud_pkg::CpW'(text_byte[3:0]);
        err                   = final_byte;
      end else if (text_byte inside {[8'hF0:8'hF4]}) begin
        st_next.bytes_pending = 2'd3;
        st_next.seq_length    = sud_pkg::Len4;
        st_next.partial_value = sud_pkg::CpW'(text_byte[2:0]);
        err                   = final_byte;
      end else begin
        err = 1'b1;
      end
    end else if (text_byte[7:6] != 2'b10) begin
      err = 1'b1;
    end else if (pend_dec == 2'd0) begin
      if (bad_value) begin
        err = 1'b1;
      end else begin
        ok             = 1'b1;
        res.code_point = shifted;
        res.seq_bytes  = st.seq_length;
      end
    end else begin
      st_next.bytes_pending = pend_dec;
      st_next.partial_value = shifted;
      err                   = final_byte;
    end

    if (err) begin
      st_next             = '0;
      st_next.skip_to_end = !final_byte;
      res                 = '0;
      res.emit            = 1'b1;
      res.status          = sud_pkg::StatusBad;
      res.text_done       = 1'b1;
    end else if (ok) begin
      st_next       = '0;
      res.emit      = 1'b1;
      res.status    = sud_pkg::StatusOk;
      res.text_done = final_byte;
    end
  end

endmodule

/* dv/strict_utf8_stream_decoder_top_test.sv */
// Testbench for the strict UTF-8 stream decoder: directed and random texts checked against a decode predictor.
`timescale 1ns / 100ps

module strict_utf8_stream_decoder_top_test;

  typedef struct packed {
    logic [sud_pkg::CpW-1:0] cp;
    logic [2:0]              len;
    logic                    st;
    logic                    done;
  } cp_note_t;

  class utf8_decode_board;
    logic [1:0]              pend;
    logic [2:0]              slen;
    logic [sud_pkg::CpW-1:0] acc;
    bit                      skipping;
    cp_note_t                want_q[$];
    int unsigned             fails;
    int unsigned             used_bytes;

    function new();
      pend = '0;
      slen = '0;
      acc = '0;
      skipping = 0;
      fails = 0;
      used_bytes = 0;
    endfunction

    function void emit_bad(logic fin);
      pend = '0;
      slen = '0;
      acc = '0;
      skipping = !fin;
      want_q.push_back('{cp: '0, len: 3'd0, st: sud_pkg::StatusBad, done: 1'b1});
    endfunction

    function void emit_ok(logic [sud_pkg::CpW-1:0] cp, logic [2:0] len, logic fin);
      pend = '0;
      slen = '0;
      acc = '0;
      want_q.push_back('{cp: cp, len: len, st: sud_pkg::StatusOk, done: fin});
    endfunction

    function void take_byte(logic [7:0] b, logic fin);
      logic [sud_pkg::CpW-1:0] lowest;
      if (skipping) begin
        if (fin) skipping = 0;
        return;
      end
      used_bytes++;
      if (pend == 2'd0) begin
        if (b == 8'h00) begin
          emit_bad(fin);
          return;
        end
        if (b < 8'h80) begin
          emit_ok({13'd0, b}, sud_pkg::Len1, fin);
          return;
        end
        if (b >= 8'hC2 && b <= 8'hDF) begin
          pend = 2'd1;
          slen = sud_pkg::Len2;
          acc = {16'd0, b[4:0]};
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          pend = 2'd2;
          slen = sud_pkg::Len3;
          acc = {17'd0, b[3:0]};
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          pend = 2'd3;
          slen = sud_pkg::Len4;
          acc = {18'd0, b[2:0]};
        end else begin
          emit_bad(fin);
          return;
        end
        if (fin) emit_bad(fin);
        return;
      end
      if (b[7:6] != 2'b10) begin
        emit_bad(fin);
        return;
      end
      acc = {acc[sud_pkg::CpW-7:0], b[5:0]};
      pend = pend - 2'd1;
      if (pend == 2'd0) begin
        lowest = (slen == sud_pkg::Len2) ? sud_pkg::Min2 :
                 (slen == sud_pkg::Len3) ? sud_pkg::Min3 : sud_pkg::Min4;
        if (acc < lowest || acc > sud_pkg::CpMax ||
            (acc >= sud_pkg::SurrLo && acc <= sud_pkg::SurrHi))
          emit_bad(fin);
        else
          emit_ok(acc, slen, fin);
        return;
      end
      if (fin) emit_bad(fin);
    endfunction

    function void check_cp(logic [sud_pkg::CpW-1:0] cp, logic [2:0] len, logic st, logic done);
      cp_note_t w;
      if (want_q.size() == 0) begin
        $error("unexpected result: code_point %0h seq_bytes %0d status %0b", cp, len, st);
        fails++;
        return;
      end
      w = want_q.pop_front();
      if (cp !== w.cp) begin
        $error("code_point expected %0h got %0h", w.cp, cp);
        fails++;
      end
      if (len !== w.len) begin
        $error("seq_bytes expected %0d got %0d", w.len, len);
        fails++;
      end
      if (st !== w.st) begin
        $error("status expected %0b got %0b", w.st, st);
        fails++;
      end
      if (done !== w.done) begin
        $error("text_done expected %0b got %0b", w.done, done);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  sud_in_if  text_if();
  sud_out_if result_if();

  strict_utf8_stream_decoder_top uut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_if),
    .result (result_if)
  );

  utf8_decode_board board = new();
  logic [7:0] text_q[$];
  bit calm;
  bit hold_req;

  // {final, byte}
  logic [8:0] directed_items [25] = '{
    9'h100, 9'h001, 9'h17F, 9'h0C2, 9'h080, 9'h0DF, 9'h1BF, 9'h0E0, 9'h0A0,
    9'h180, 9'h0F4, 9'h08F, 9'h0BF, 9'h1BF, 9'h0E0, 9'h09F, 9'h0BF, 9'h141,
    9'h1C1, 9'h0FF, 9'h141, 9'h0ED, 9'h0A0, 9'h180, 9'h1C3
  };

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (result_if.valid && result_if.ready)
        board.check_cp(result_if.code_point, result_if.seq_bytes, result_if.status,
                       result_if.text_done);
      if (text_if.valid && text_if.ready)
        board.take_byte(text_if.text_byte, text_if.final_byte);
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic void put_utf8(int unsigned cp);
    if (cp < 'h80) begin
      text_q.push_back(8'(cp));
    end else if (cp < 'h800) begin
      text_q.push_back(8'('hC0 | (cp >> 6)));
      text_q.push_back(8'('h80 | (cp & 'h3F)));
    end else if (cp < 'h10000) begin
      text_q.push_back(8'('hE0 | (cp >> 12)));
      text_q.push_back(8'('h80 | ((cp >> 6) & 'h3F)));
      text_q.push_back(8'('h80 | (cp & 'h3F)));
    end else begin
      text_q.push_back(8'('hF0 | (cp >> 18)));
      text_q.push_back(8'('h80 | ((cp >> 12) & 'h3F)));
      text_q.push_back(8'('h80 | ((cp >> 6) & 'h3F)));
      text_q.push_back(8'('h80 | (cp & 'h3F)));
    end
  endfunction

  function automatic int unsigned pick_cp();
    int unsigned edges[10] = '{'h1, 'h7F, 'h80, 'h7FF, 'h800, 'hD7FF, 'hE000, 'hFFFF,
                               'h10000, 'h10FFFF};
    int unsigned cp;
    if ($urandom_range(0, 7) == 0) return edges[$urandom_range(0, 9)];
    case ($urandom_range(0, 3))
      0: cp = $urandom_range('h01, 'h7F);
      1: cp = $urandom_range('h80, 'h7FF);
      2: begin
        cp = $urandom_range('h800, 'hFFFF);
        if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp + 'h800;
      end
      default: cp = $urandom_range('h10000, 'h10FFFF);
    endcase
    return cp;
  endfunction

  function automatic void put_noise();
    int unsigned cp;
    int unsigned len;
    logic [7:0] b;
    case ($urandom_range(0, 6))
      0: text_q.push_back(8'($urandom_range(0, 255)));
      1: begin
        cp = $urandom_range('h80, 'h10FFFF);
        len = (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
        put_utf8(cp);
        repeat ($urandom_range(1, len - 1)) void'(text_q.pop_back());
      end
      2: begin
        text_q.push_back(8'($urandom_range('hC2, 'hF4)));
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        text_q.push_back(b);
      end
      3: begin
        case ($urandom_range(0, 2))
          0: begin
            text_q.push_back(8'($urandom_range('hC0, 'hC1)));
            text_q.push_back(cont_byte());
          end
          1: begin
            text_q.push_back(8'hE0);
            text_q.push_back(8'($urandom_range('h80, 'h9F)));
            text_q.push_back(cont_byte());
          end
          default: begin
            text_q.push_back(8'hF0);
            text_q.push_back(8'($urandom_range('h80, 'h8F)));
            text_q.push_back(cont_byte());
            text_q.push_back(cont_byte());
          end
        endcase
      end
      4: begin
        text_q.push_back(8'hED);
        text_q.push_back(8'($urandom_range('hA0, 'hBF)));
        text_q.push_back(cont_byte());
      end
      5: begin
        if ($urandom_range(0, 1)) begin
          text_q.push_back(8'hF4);
          text_q.push_back(8'($urandom_range('h90, 'hBF)));
          text_q.push_back(cont_byte());
          text_q.push_back(cont_byte());
        end else begin
          text_q.push_back(8'($urandom_range('hF5, 'hFF)));
        end
      end
      default: text_q.push_back(8'h00);
    endcase
  endfunction

  task automatic idle_in(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      text_if.valid <= 1'b0;
    end
  endtask

  task automatic send_byte(logic [7:0] b, logic fin);
    @(negedge clk);
    text_if.valid      <= 1'b1;
    text_if.text_byte  <= b;
    text_if.final_byte <= fin;
    @(posedge clk);
    while (!text_if.ready) @(posedge clk);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1);
      if (!calm) idle_in(gap_len());
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    text_if.valid <= 1'b0;
    while (board.want_q.size() != 0) @(posedge clk);
  endtask

  // receiver stalls long while a steady stream keeps coming, so input backs up
  task automatic fill_while_held();
    hold_req = 1'b1;
    text_q.delete();
    repeat (24) text_q.push_back(8'($urandom_range('h20, 'h7E)));
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    wait_drained();
  endtask

  initial begin : rx_side
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left = 0;
    stall_left = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        result_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        result_if.ready <= 1'b0;
        stall_left--;
      end else begin
        result_if.ready <= 1'b1;
        stall_left = gap_len();
      end
    end
  end

  initial begin
    #16_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned text_no;
    int unsigned nchars;
    int unsigned wait_cycles;
    clk = 1'b0;
    rst = 1'b1;
    calm = 1'b0;
    hold_req = 1'b0;
    text_if.valid = 1'b0;
    text_if.text_byte = '0;
    text_if.final_byte = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_items[i]) begin
      send_byte(directed_items[i][7:0], directed_items[i][8]);
      idle_in(gap_len());
    end
    wait_drained();
    fill_while_held();

    text_no = 0;
    while (board.used_bytes < 1500) begin
      if (text_no % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if (text_no == 120) fill_while_held();
      if (text_no % 90 == 89) wait_drained();
      text_q.delete();
      nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
      repeat (nchars) begin
        if ($urandom_range(0, 99) < 8) put_noise();
        else put_utf8(pick_cp());
      end
      send_text();
      text_no++;
    end

    @(negedge clk);
    text_if.valid <= 1'b0;
    wait_cycles = 0;
    while (board.want_q.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (4) @(posedge clk);
    if (board.want_q.size() != 0) begin
      $error("%0d expected results never arrived", board.want_q.size());
      board.fails++;
    end
    if (board.fails == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/sud_pkg.sv
design/sud_in_if.sv
design/sud_out_if.sv
design/sud_step.sv
design/strict_utf8_stream_decoder_top.sv
dv/strict_utf8_stream_decoder_top_test.sv
